// ===== rtl/gre_pkg.sv =====
// Package for the gated reciprocal frequency estimator.
// Holds register codes, the configuration struct, the sequencer states and scale tables.
// No dependencies.
`default_nettype none

package gre_pkg;

    localparam int COUNT_W   = 32;
    localparam int FREQ_W    = 54;
    localparam int WIDE_W    = FREQ_W + 4;
    localparam int SCALE_W   = 14;
    localparam int DEC_IDX_W = 5;

    localparam logic [FREQ_W-1:0]  FREQ_MAX_MHZ = 54'd10000000000000000;
    localparam logic [COUNT_W-1:0] GATE_MIN     = 32'd1000;

    typedef enum logic [1:0] {
        REG_METER_ENABLED    = 2'd0,
        REG_GATE_TIME        = 2'd1,
        REG_REF_CLOCK        = 2'd2,
        REG_PERIODS_EXPONENT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic       meter_enabled;
        logic [1:0] gate_time;
        logic [1:0] ref_clock;
        logic [2:0] periods_exponent;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_SCALE,
        ST_PUB
    } state_t;

    // mHz per gate count for each gate time code; code 3 acts as 10 s
    function automatic logic [SCALE_W-1:0] gate_scale(input logic [1:0] code);
        logic [SCALE_W-1:0] s;
        unique case (code)
            2'd0:    s = 14'd10000;
            2'd1:    s = 14'd1000;
            default: s = 14'd100;
        endcase
        return s;
    endfunction

    // Ten to the power idx for the period numerators (1e8 up to 1e16)
    function automatic logic [FREQ_W-1:0] pow10(input logic [DEC_IDX_W-1:0] idx);
        logic [FREQ_W-1:0] p;
        unique case (idx)
            5'd8:    p = 54'd100000000;
            5'd9:    p = 54'd1000000000;
            5'd10:   p = 54'd10000000000;
            5'd11:   p = 54'd100000000000;
            5'd12:   p = 54'd1000000000000;
            5'd13:   p = 54'd10000000000000;
            5'd14:   p = 54'd100000000000000;
            5'd15:   p = 54'd1000000000000000;
            5'd16:   p = 54'd10000000000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gated_reciprocal_freq_estimator.sv =====
// Gated reciprocal frequency estimator: gate and period counts in, mHz out.
// Gate item: result after the multiply, saturate, scale and publish states. Period item:
// 54-step divider, then quotient load, saturate, scale and publish; a zero period count
// skips the divider. One item at a time; s_tready is high only while the sequencer idles.
// Items that yield no result are absorbed in the cycle they are accepted.
// Reset (rst_n, async, active low) clears the sequencer, use_period, previous value and
// the output valid; registers return to meter on, gate 1 s, 100 kHz ref, one period.
// Depends on gre_pkg, gre_regs and gre_div.
`default_nettype none

module gated_reciprocal_freq_estimator
    import gre_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] count
    input  wire logic        s_tuser,   // [0] kind: 0 gate, 1 period
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [53:0] frequency_mhz, [55:54] zero
    output logic             m_tuser    // [0] unstable
);

    cfg_t cfg;

    gre_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t state_reg, state_next;

    logic                 use_period_reg;
    logic [FREQ_W-1:0]    prev_reg;
    logic [FREQ_W-1:0]    raw_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [WIDE_W-1:0]    raw10_reg;
    logic [WIDE_W-1:0]    lo_reg;
    logic [WIDE_W-1:0]    hi_reg;
    logic                 out_valid_reg;
    logic [FREQ_W-1:0]    out_freq_reg;
    logic                 out_bad_reg;

    logic                 accept;
    logic                 is_gate;
    logic                 small_gate;
    logic                 zero_count;
    logic                 out_free;
    logic                 bad;
    logic [2:0]           exp_clamped;
    logic [DEC_IDX_W-1:0] dec_idx;
    logic [FREQ_W-1:0]    numer;

    logic                 div_start;
    logic                 div_done;
    logic [FREQ_W-1:0]    div_quo;

    // sequencer strobes
    logic ld_gate, ld_zero, set_up, clr_up, ld_div, ld_sat, ld_scale, ld_out;

    assign accept     = s_tvalid & s_tready;
    assign is_gate    = ~s_tuser;
    assign small_gate = (s_tdata < GATE_MIN);
    assign zero_count = (s_tdata == '0);
    assign out_free   = ~out_valid_reg | m_tready;

    // Numerator is 10^(5+ref) * 10^exp * 1000; fallback is 1e9
    assign exp_clamped = (cfg.periods_exponent > 3'd5) ? 3'd5 : cfg.periods_exponent;
    assign dec_idx     = cfg.meter_enabled
                       ? DEC_IDX_W'(5'd8 + {3'b0, cfg.ref_clock} + {2'b0, exp_clamped})
                       : DEC_IDX_W'(5'd9);
    assign numer       = pow10(dec_idx);

    gre_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (numer),
        .divisor  (s_tdata),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Unstable when 10*new falls outside [9*prev, 11*prev]
    assign bad = (raw10_reg < lo_reg) || (raw10_reg > hi_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_gate && !use_period_reg && !small_gate)
                        state_next = ST_MUL;
                    else if (!is_gate && use_period_reg)
                        state_next = zero_count ? ST_SAT : ST_DIV;
                end
            end
            ST_MUL:   state_next = ST_SAT;
            ST_DIV:   if (div_done) state_next = ST_SAT;
            ST_SAT:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_PUB;
            ST_PUB:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        ld_gate   = 1'b0;
        ld_zero   = 1'b0;
        set_up    = 1'b0;
        clr_up    = 1'b0;
        div_start = 1'b0;
        ld_div    = 1'b0;
        ld_sat    = 1'b0;
        ld_scale  = 1'b0;
        ld_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    if (is_gate && !use_period_reg)
                    begin
                        // a coarse gate count hands over to the period count
                        set_up  = small_gate;
                        ld_gate = ~small_gate;
                    end
                    else if (!is_gate && use_period_reg)
                    begin
                        clr_up    = 1'b1;
                        ld_zero   = zero_count;
                        div_start = ~zero_count;
                    end
                end
            end
            ST_MUL:   ;
            ST_DIV:   ld_div = div_done;
            ST_SAT:   ld_sat = 1'b1;
            ST_SCALE: ld_scale = 1'b1;
            ST_PUB:   ld_out = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            use_period_reg <= 1'b0;
            prev_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (set_up)
                use_period_reg <= 1'b1;
            else if (clr_up)
                use_period_reg <= 1'b0;
            // keep the raw value as reference whether stable or not
            if (ld_out)
            begin
                prev_reg      <= raw_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_gate)
        begin
            count_reg <= s_tdata;
            scale_reg <= cfg.meter_enabled ? gate_scale(cfg.gate_time) : 14'd10000;
        end
        if (state_reg == ST_MUL)
            raw_reg <= FREQ_W'({22'b0, count_reg} * {40'b0, scale_reg});
        else if (ld_zero)
            raw_reg <= '0;
        else if (ld_div)
            raw_reg <= div_quo;
        else if (ld_sat && (raw_reg > FREQ_MAX_MHZ))
            raw_reg <= FREQ_MAX_MHZ;
        if (ld_scale)
        begin
            raw10_reg <= {1'b0, raw_reg, 3'b0} + {3'b0, raw_reg, 1'b0};
            lo_reg    <= {1'b0, prev_reg, 3'b0} + {4'b0, prev_reg};
            hi_reg    <= {1'b0, prev_reg, 3'b0} + {3'b0, prev_reg, 1'b0} + {4'b0, prev_reg};
        end
        if (ld_out)
        begin
            out_freq_reg <= bad ? '0 : raw_reg;
            out_bad_reg  <= bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b0, out_freq_reg};
    assign m_tuser  = out_bad_reg;

endmodule

`default_nettype wire

// ===== rtl/gre_regs.sv =====
// APB configuration registers for the frequency estimator.
// Depends on gre_pkg for the register codes and the cfg_t struct.
`default_nettype none

module gre_regs
    import gre_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.meter_enabled    <= 1'b1;
            cfg_reg.gate_time        <= 2'd1;
            cfg_reg.ref_clock        <= 2'd0;
            cfg_reg.periods_exponent <= 3'd0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_METER_ENABLED:    cfg_reg.meter_enabled    <= pwdata[0];
                REG_GATE_TIME:        cfg_reg.gate_time        <= pwdata[1:0];
                REG_REF_CLOCK:        cfg_reg.ref_clock        <= pwdata[1:0];
                REG_PERIODS_EXPONENT: cfg_reg.periods_exponent <= pwdata[2:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_METER_ENABLED:    prdata[0]   = cfg_reg.meter_enabled;
            REG_GATE_TIME:        prdata[1:0] = cfg_reg.gate_time;
            REG_REF_CLOCK:        prdata[1:0] = cfg_reg.ref_clock;
            REG_PERIODS_EXPONENT: prdata[2:0] = cfg_reg.periods_exponent;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/gre_div.sv =====
// Restoring divider, one quotient bit per cycle, for the period path.
// Depends on gre_pkg for the dividend and divisor widths.
`default_nettype none

module gre_div
    import gre_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [FREQ_W-1:0]  dividend,
    input  wire logic [COUNT_W-1:0] divisor,
    output logic                    done,
    output logic [FREQ_W-1:0]       quotient
);

    localparam int STEP_W = $clog2(FREQ_W);

    logic [FREQ_W-1:0]  quo_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] dsr_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               ge;
    logic               last;

    assign trial    = {rem_reg, quo_reg[FREQ_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign ge       = (trial >= {1'b0, dsr_reg});
    assign last     = (cnt_reg == STEP_W'(FREQ_W - 1));
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg & last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Shift the dividend out at the top while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[FREQ_W-2:0], ge};
            rem_reg <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        end
    end

endmodule

`default_nettype wire
